FILE: rtl/sha512_pkg.sv
// ----------------------------------------------------------------------------
// sha512_pkg
// Shared types, constants and round functions for the SHA-512 hash engine.
// ----------------------------------------------------------------------------
package sha512_pkg;

    localparam int WordW  = 64;
    localparam int Rounds = 80;
    localparam int QDepth = 4;
    localparam int QPtrW  = 2;

    localparam logic [7:0] PadByte   = 8'h80;
    localparam logic [6:0] PadLimit  = 7'd112;

    typedef logic [WordW-1:0] word_t;

    // one queue entry from the front part to the back part
    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       last;
    } item_t;

    function automatic word_t init_hash(input logic [2:0] idx);
        word_t h;
        begin
            case (idx)
                3'd0: h = 64'h6A09E667F3BCC908;
                3'd1: h = 64'hBB67AE8584CAA73B;
                3'd2: h = 64'h3C6EF372FE94F82B;
                3'd3: h = 64'hA54FF53A5F1D36F1;
                3'd4: h = 64'h510E527FADE682D1;
                3'd5: h = 64'h9B05688C2B3E6C1F;
                3'd6: h = 64'h1F83D9ABFB41BD6B;
                default: h = 64'h5BE0CD19137E2179;
            endcase
            return h;
        end
    endfunction

    function automatic word_t round_k(input logic [6:0] t);
        word_t k;
        begin
            case (t)
                7'd0: k = 64'h428a2f98d728ae22;  7'd1: k = 64'h7137449123ef65cd;
                7'd2: k = 64'hb5c0fbcfec4d3b2f;  7'd3: k = 64'he9b5dba58189dbbc;
                7'd4: k = 64'h3956c25bf348b538;  7'd5: k = 64'h59f111f1b605d019;
                7'd6: k = 64'h923f82a4af194f9b;  7'd7: k = 64'hab1c5ed5da6d8118;
                7'd8: k = 64'hd807aa98a3030242;  7'd9: k = 64'h12835b0145706fbe;
                7'd10: k = 64'h243185be4ee4b28c; 7'd11: k = 64'h550c7dc3d5ffb4e2;
                7'd12: k = 64'h72be5d74f27b896f; 7'd13: k = 64'h80deb1fe3b1696b1;
                7'd14: k = 64'h9bdc06a725c71235; 7'd15: k = 64'hc19bf174cf692694;
                7'd16: k = 64'he49b69c19ef14ad2; 7'd17: k = 64'hefbe4786384f25e3;
                7'd18: k = 64'h0fc19dc68b8cd5b5; 7'd19: k = 64'h240ca1cc77ac9c65;
                7'd20: k = 64'h2de92c6f592b0275; 7'd21: k = 64'h4a7484aa6ea6e483;
                7'd22: k = 64'h5cb0a9dcbd41fbd4; 7'd23: k = 64'h76f988da831153b5;
                7'd24: k = 64'h983e5152ee66dfab; 7'd25: k = 64'ha831c66d2db43210;
                7'd26: k = 64'hb00327c898fb213f; 7'd27: k = 64'hbf597fc7beef0ee4;
                7'd28: k = 64'hc6e00bf33da88fc2; 7'd29: k = 64'hd5a79147930aa725;
                7'd30: k = 64'h06ca6351e003826f; 7'd31: k = 64'h142929670a0e6e70;
                7'd32: k = 64'h27b70a8546d22ffc; 7'd33: k = 64'h2e1b21385c26c926;
                7'd34: k = 64'h4d2c6dfc5ac42aed; 7'd35: k = 64'h53380d139d95b3df;
                7'd36: k = 64'h650a73548baf63de; 7'd37: k = 64'h766a0abb3c77b2a8;
                7'd38: k = 64'h81c2c92e47edaee6; 7'd39: k = 64'h92722c851482353b;
                7'd40: k = 64'ha2bfe8a14cf10364; 7'd41: k = 64'ha81a664bbc423001;
                7'd42: k = 64'hc24b8b70d0f89791; 7'd43: k = 64'hc76c51a30654be30;
                7'd44: k = 64'hd192e819d6ef5218; 7'd45: k = 64'hd69906245565a910;
                7'd46: k = 64'hf40e35855771202a; 7'd47: k = 64'h106aa07032bbd1b8;
                7'd48: k = 64'h19a4c116b8d2d0c8; 7'd49: k = 64'h1e376c085141ab53;
                7'd50: k = 64'h2748774cdf8eeb99; 7'd51: k = 64'h34b0bcb5e19b48a8;
                7'd52: k = 64'h391c0cb3c5c95a63; 7'd53: k = 64'h4ed8aa4ae3418acb;
                7'd54: k = 64'h5b9cca4f7763e373; 7'd55: k = 64'h682e6ff3d6b2b8a3;
                7'd56: k = 64'h748f82ee5defb2fc; 7'd57: k = 64'h78a5636f43172f60;
                7'd58: k = 64'h84c87814a1f0ab72; 7'd59: k = 64'h8cc702081a6439ec;
                7'd60: k = 64'h90befffa23631e28; 7'd61: k = 64'ha4506cebde82bde9;
                7'd62: k = 64'hbef9a3f7b2c67915; 7'd63: k = 64'hc67178f2e372532b;
                7'd64: k = 64'hca273eceea26619c; 7'd65: k = 64'hd186b8c721c0c207;
                7'd66: k = 64'heada7dd6cde0eb1e; 7'd67: k = 64'hf57d4f7fee6ed178;
                7'd68: k = 64'h06f067aa72176fba; 7'd69: k = 64'h0a637dc5a2c898a6;
                7'd70: k = 64'h113f9804bef90dae; 7'd71: k = 64'h1b710b35131c471b;
                7'd72: k = 64'h28db77f523047d84; 7'd73: k = 64'h32caab7b40c72493;
                7'd74: k = 64'h3c9ebe0a15c9bebc; 7'd75: k = 64'h431d67c49c100d4c;
                7'd76: k = 64'h4cc5d4becb3e42b6; 7'd77: k = 64'h597f299cfc657e2a;
                7'd78: k = 64'h5fcb6fab3ad6faec; 7'd79: k = 64'h6c44198c4a475817;
                default: k = '0;
            endcase
            return k;
        end
    endfunction

    function automatic word_t rotr(input word_t x, input int n);
        return (x >> n) | (x << (WordW - n));
    endfunction

endpackage

FILE: rtl/sha512_if.sv
// ----------------------------------------------------------------------------
// sha512_in_if / sha512_out_if
// Valid/ready channels for message bytes and digest words.
// ----------------------------------------------------------------------------
interface sha512_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last;
    modport source (output valid, data_byte, has_byte, last, input ready);
    modport sink   (input valid, data_byte, has_byte, last, output ready);
endinterface

interface sha512_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
    modport source (output valid, digest_word, word_index, last_word, input ready);
    modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

FILE: rtl/sha512_front.sv
// ----------------------------------------------------------------------------
// sha512_front
// Input stage: takes byte beats into a short queue for the core.
// ----------------------------------------------------------------------------
module sha512_front
    import sha512_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    sha512_in_if.sink    in_ch,
    output logic         q_valid,
    output item_t        q_item,
    input  logic         q_pop
);
    item_t            mem_reg [QDepth];
    logic [QPtrW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QPtrW:0]   cnt_reg;
    logic             push;

    assign in_ch.ready = (cnt_reg != (QPtrW+1)'(QDepth)) ? 1'b1 : 1'b0;
    assign push        = in_ch.valid && in_ch.ready;
    assign q_valid     = (cnt_reg != '0);
    assign q_item      = mem_reg[rd_ptr_reg];

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= '{in_ch.data_byte, in_ch.has_byte, in_ch.last};
        end
    end

    // pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (q_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            cnt_reg <= cnt_reg + {2'b0, push} - {2'b0, q_pop};
        end
    end
endmodule

FILE: rtl/sha512_core.sv
// ----------------------------------------------------------------------------
// sha512_core
// Block assembly, padding, 80-round compression and digest output.
// ----------------------------------------------------------------------------
module sha512_core
    import sha512_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_valid,
    input  item_t         q_item,
    output logic          q_pop,
    sha512_out_if.source  out_ch
);
    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_ROUND = 6'b000010,
        S_ADD   = 6'b000100,
        S_PAD   = 6'b001000,
        S_PAD2  = 6'b010000,
        S_OUT   = 6'b100000
    } state_t;

    state_t        state_reg;
    word_t         h_reg [8];
    word_t         v_reg [8];
    word_t         w_reg [16];
    word_t         buf_reg [16];
    logic [6:0]    fill_reg;
    logic [127:0]  bits_reg;
    logic [6:0]    t_reg;
    logic          final_reg;   // this compression belongs to the padding
    logic          second_reg;  // a further padded or length-only block follows
    logic [2:0]    oidx_reg;

    word_t t1, t2, s0, s1, wnew, e, a;
    logic [3:0] wi;
    logic [5:0] sh;

    assign q_pop = (state_reg == S_IDLE) && q_valid;
    assign wi    = fill_reg[6:3];
    assign sh    = 6'((7 - fill_reg[2:0]) * 8);

    // round datapath
    always_comb
    begin
        e  = v_reg[4];
        a  = v_reg[0];
        t1 = v_reg[7] + (rotr(e, 14) ^ rotr(e, 18) ^ rotr(e, 41))
           + ((e & v_reg[5]) ^ (~e & v_reg[6])) + round_k(t_reg) + w_reg[0];
        t2 = (rotr(a, 28) ^ rotr(a, 34) ^ rotr(a, 39))
           + ((a & v_reg[1]) ^ (a & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
        s0 = rotr(w_reg[1], 1) ^ rotr(w_reg[1], 8) ^ (w_reg[1] >> 7);
        s1 = rotr(w_reg[14], 19) ^ rotr(w_reg[14], 61) ^ (w_reg[14] >> 6);
        wnew = s1 + w_reg[9] + s0 + w_reg[0];
    end

    assign out_ch.valid       = (state_reg == S_OUT);
    assign out_ch.digest_word = h_reg[oidx_reg];
    assign out_ch.word_index  = oidx_reg;
    assign out_ch.last_word   = (oidx_reg == 3'd7);

    // datapath registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (q_pop && q_item.has_byte)
                begin
                    if (fill_reg[2:0] == 3'd0)
                        buf_reg[wi] <= word_t'(q_item.data_byte) << sh;
                    else
                        buf_reg[wi] <= buf_reg[wi] | (word_t'(q_item.data_byte) << sh);
                    if (fill_reg == 7'd127)
                    begin
                        for (int i = 0; i < 15; i++)
                            w_reg[i] <= buf_reg[i];
                        w_reg[15] <= buf_reg[15] | word_t'(q_item.data_byte);
                        for (int i = 0; i < 8; i++)
                            v_reg[i] <= h_reg[i];
                    end
                end
            end
            S_PAD:
            begin
                // build padded block from the partial buffer
                for (int i = 0; i < 16; i++)
                begin
                    if (4'(i) == wi)
                        w_reg[i] <= ((fill_reg[2:0] != 3'd0) ? buf_reg[i] : '0)
                                  | (word_t'(PadByte) << sh);
                    else if (4'(i) < wi)
                        w_reg[i] <= buf_reg[i];
                    else if (i == 14 && fill_reg < PadLimit)
                        w_reg[i] <= bits_reg[127:64];
                    else if (i == 15 && fill_reg < PadLimit)
                        w_reg[i] <= bits_reg[63:0];
                    else
                        w_reg[i] <= '0;
                end
                for (int i = 0; i < 8; i++)
                    v_reg[i] <= h_reg[i];
            end
            S_PAD2:
            begin
                for (int i = 0; i < 14; i++)
                    w_reg[i] <= '0;
                w_reg[14] <= bits_reg[127:64];
                w_reg[15] <= bits_reg[63:0];
                for (int i = 0; i < 8; i++)
                    v_reg[i] <= h_reg[i];
            end
            S_ROUND:
            begin
                for (int i = 0; i < 15; i++)
                    w_reg[i] <= w_reg[i+1];
                w_reg[15] <= wnew;
                for (int i = 1; i < 8; i++)
                begin
                    if (i != 4)
                        v_reg[i] <= v_reg[i-1];
                end
                v_reg[4] <= v_reg[3] + t1;
                v_reg[0] <= t1 + t2;
            end
            default:
            begin
            end
        endcase
    end

    // control and chaining words
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            fill_reg   <= '0;
            bits_reg   <= '0;
            t_reg      <= '0;
            final_reg  <= 1'b0;
            second_reg <= 1'b0;
            oidx_reg   <= '0;
            for (int i = 0; i < 8; i++)
                h_reg[i] <= init_hash(3'(i));
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (q_pop)
                    begin
                        final_reg  <= 1'b0;
                        second_reg <= q_item.last;
                        if (q_item.has_byte)
                        begin
                            fill_reg <= fill_reg + 1'b1;
                            bits_reg <= bits_reg + 128'd8;
                        end
                        t_reg <= '0;
                        if (q_item.has_byte && fill_reg == 7'd127)
                            state_reg <= S_ROUND;
                        else if (q_item.last)
                            state_reg <= S_PAD;
                    end
                end
                S_PAD:
                begin
                    final_reg  <= 1'b1;
                    second_reg <= (fill_reg >= PadLimit);
                    t_reg      <= '0;
                    state_reg  <= S_ROUND;
                end
                S_PAD2:
                begin
                    final_reg  <= 1'b1;
                    second_reg <= 1'b0;
                    t_reg      <= '0;
                    state_reg  <= S_ROUND;
                end
                S_ROUND:
                begin
                    t_reg <= t_reg + 1'b1;
                    if (t_reg == 7'(Rounds - 1))
                        state_reg <= S_ADD;
                end
                S_ADD:
                begin
                    for (int i = 0; i < 8; i++)
                        h_reg[i] <= h_reg[i] + v_reg[i];
                    oidx_reg <= '0;
                    if (!final_reg)
                        state_reg <= second_reg ? S_PAD : S_IDLE;
                    else if (second_reg)
                        state_reg <= S_PAD2;
                    else
                        state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_ch.ready)
                    begin
                        oidx_reg <= oidx_reg + 1'b1;
                        if (oidx_reg == 3'd7)
                        begin
                            for (int i = 0; i < 8; i++)
                                h_reg[i] <= init_hash(3'(i));
                            fill_reg  <= '0;
                            bits_reg  <= '0;
                            state_reg <= S_IDLE;
                        end
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

FILE: rtl/sha512_hash_engine.sv
// ----------------------------------------------------------------------------
// sha512_hash_engine
// SHA-512 over a byte stream; emits eight 64-bit digest words per message.
// ----------------------------------------------------------------------------
//  channel  | dir | payload
//  in_ch    | in  | data_byte[7:0], has_byte, last
//  out_ch   | out | digest_word[63:0], word_index[2:0], last_word
//
//  The 128th byte of a block starts the 80-round loop, one round a cycle,
//  then an add step. A last beat adds one or two padded compressions,
//  then 8 output beats.
//  A 4-entry queue takes beats while the core compresses, until it is full.
//  rst_n clears control state and loads the initial hash values.
module sha512_hash_engine
    import sha512_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    sha512_in_if.sink     in_ch,
    sha512_out_if.source  out_ch
);
    logic  q_valid, q_pop;
    item_t q_item;

    sha512_front u_front (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch),
        .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
    );

    sha512_core u_core (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_item(q_item),
        .q_pop(q_pop), .out_ch(out_ch)
    );
endmodule
